@@ rtl/stl_pkg.sv @@
`timescale 1ns / 1ps

package stl_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL = 3'd1;
    localparam logic [2:0] ST_TOO_LONG   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_IDX_RANGE  = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic push_char;
        logic commit;
        logic find_step;
        logic clear_run;
        logic sel_find;
    } stl_ctl_t;

    typedef struct packed {
        logic        taken;
        logic [3:0]  index;
        logic [31:0] value;
        logic [7:0]  name_char;
    } chain_t;

endpackage

@@ rtl/stl_cell.sv @@
`timescale 1ns / 1ps

module stl_cell import stl_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int NAME_LEN = 64,
    parameter int CW = 5,
    parameter int PW = 7,
    parameter int AW = 6,
    parameter int LW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stl_ctl_t      ctl,
    input  logic [7:0]    name_char,
    input  logic [PW-1:0] pos,
    input  logic [AW-1:0] rd_addr_next,
    input  logic [31:0]   value_in,
    input  logic [CW-1:0] count,
    input  logic [3:0]    rd_index,
    input  chain_t        chain_in,
    input  logic [LW-1:0] len_in,
    output chain_t        chain_out,
    output logic [LW-1:0] len_out
);

    localparam int DEPTH = NAME_LEN - 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg;
    logic [31:0]   value_reg;
    logic          flag_reg;
    logic          flag_next;
    logic          is_slot;
    logic          valid;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          match_now;
    logic          hit_here;
    logic          take;

    assign is_slot   = (CELL_IDX == int'(count));
    assign valid     = (CELL_IDX < int'(count));
    assign wr_en     = ctl.push_char && is_slot && (int'(pos) < DEPTH);
    assign wr_addr   = AW'(pos);
    assign match_now = valid && flag_reg && (int'(pos) < int'(len_reg))
                       && (rd_data_reg == name_char);
    assign hit_here  = match_now && (int'(len_reg) == int'(pos) + 1);
    assign take      = ctl.sel_find ? hit_here : (int'(rd_index) == CELL_IDX);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= name_char;
        end
        if (wr_en && (wr_addr == rd_addr_next)) begin
            rd_data_reg <= name_char;
        end else begin
            rd_data_reg <= mem[rd_addr_next];
        end
        if (ctl.commit && is_slot) begin
            len_reg   <= LW'(int'(pos) + 1);
            value_reg <= value_in;
        end
    end

    always_comb begin
        flag_next = flag_reg;
        if (ctl.clear_run) begin
            flag_next = 1'b1;
        end else if (ctl.find_step) begin
            flag_next = match_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b1;
        end else begin
            flag_reg <= flag_next;
        end
    end

    always_comb begin
        chain_out = chain_in;
        len_out   = len_in;
        if (take && !chain_in.taken) begin
            chain_out.taken     = 1'b1;
            chain_out.index     = 4'(CELL_IDX);
            chain_out.value     = value_reg;
            chain_out.name_char = rd_data_reg;
            len_out             = len_reg;
        end
    end

endmodule

@@ rtl/stl_ctrl.sv @@
`timescale 1ns / 1ps

module stl_ctrl import stl_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int NAME_LEN = 64,
    parameter int CW = 5,
    parameter int PW = 7,
    parameter int AW = 6,
    parameter int LW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    op,
    input  logic          name_last,
    input  logic [31:0]   value_in,
    input  logic [3:0]    entry_index,
    input  chain_t        chain_end,
    input  logic [LW-1:0] len_end,
    output stl_ctl_t      ctl,
    output logic [PW-1:0] pos,
    output logic [AW-1:0] rd_addr_next,
    output logic [CW-1:0] count,
    output logic [3:0]    rd_index,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [3:0]    m_index,
    output logic [31:0]   m_value,
    output logic [7:0]    m_char,
    output logic          m_last,
    output logic [4:0]    m_count
);

    localparam int DEPTH = NAME_LEN - 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          too_long_reg, too_long_next;
    logic [LW-1:0] k_reg, k_next;
    logic [3:0]    rd_idx_reg, rd_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [3:0]    index_reg, index_next;
    logic [31:0]   value_reg, value_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic [4:0]    ecount_reg, ecount_next;
    logic          out_free;
    logic          accept;
    logic          read_last;
    logic [PW-1:0] pos_adv;
    logic          too_long_adv;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign read_last    = (int'(k_reg) + 1 == int'(len_end));
    assign pos_adv      = (int'(pos_reg) < NAME_LEN) ? PW'(int'(pos_reg) + 1) : pos_reg;
    assign too_long_adv = too_long_reg || (int'(pos_reg) >= NAME_LEN - 1);

    always_comb begin
        state_next = state_reg;
        if (state_reg == S_IDLE) begin
            if (accept && (op == OP_READ) && (int'(entry_index) < int'(count_reg))) begin
                state_next = S_READ;
            end
        end else begin
            if (out_free && read_last) begin
                state_next = S_IDLE;
            end
        end
    end

    always_comb begin
        ctl           = '0;
        ctl.sel_find  = (state_reg == S_IDLE) && (op == OP_FIND);
        count_next    = count_reg;
        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        k_next        = k_reg;
        rd_idx_next   = rd_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        index_next    = index_reg;
        value_next    = value_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        ecount_next   = ecount_reg;
        if (state_reg == S_IDLE) begin
            if (accept) begin
                unique case (op)
                    OP_PUSH: begin
                        ctl.push_char = (int'(count_reg) < ENTRIES);
                        pos_next      = pos_adv;
                        too_long_next = too_long_adv;
                        if (name_last) begin
                            ctl.clear_run = 1'b1;
                            pos_next      = '0;
                            too_long_next = 1'b0;
                            m_valid_next  = 1'b1;
                            index_next    = '0;
                            value_next    = '0;
                            char_next     = '0;
                            last_next     = 1'b1;
                            ecount_next   = 5'(count_reg);
                            if (int'(count_reg) >= ENTRIES) begin
                                status_next = ST_TABLE_FULL;
                            end else if (too_long_adv) begin
                                status_next = ST_TOO_LONG;
                            end else begin
                                ctl.commit  = 1'b1;
                                count_next  = CW'(int'(count_reg) + 1);
                                status_next = ST_OK;
                                index_next  = 4'(count_reg);
                                value_next  = value_in;
                                ecount_next = 5'(int'(count_reg) + 1);
                            end
                        end
                    end
                    OP_FIND: begin
                        pos_next      = pos_adv;
                        too_long_next = too_long_adv;
                        if (!name_last) begin
                            ctl.find_step = 1'b1;
                        end else begin
                            ctl.clear_run = 1'b1;
                            pos_next      = '0;
                            too_long_next = 1'b0;
                            m_valid_next  = 1'b1;
                            char_next     = '0;
                            last_next     = 1'b1;
                            ecount_next   = 5'(count_reg);
                            if (chain_end.taken) begin
                                status_next = ST_OK;
                                index_next  = chain_end.index;
                                value_next  = chain_end.value;
                            end else begin
                                status_next = ST_NOT_FOUND;
                                index_next  = '0;
                                value_next  = '0;
                            end
                        end
                    end
                    OP_READ: begin
                        ctl.clear_run = 1'b1;
                        pos_next      = '0;
                        too_long_next = 1'b0;
                        rd_idx_next   = entry_index;
                        k_next        = '0;
                        if (int'(entry_index) >= int'(count_reg)) begin
                            m_valid_next = 1'b1;
                            status_next  = ST_IDX_RANGE;
                            index_next   = '0;
                            value_next   = '0;
                            char_next    = '0;
                            last_next    = 1'b1;
                            ecount_next  = 5'(count_reg);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            if (out_free) begin
                m_valid_next = 1'b1;
                status_next  = ST_OK;
                index_next   = rd_idx_reg;
                value_next   = chain_end.value;
                char_next    = chain_end.name_char;
                last_next    = read_last;
                ecount_next  = 5'(count_reg);
                k_next       = read_last ? '0 : LW'(int'(k_reg) + 1);
            end
        end
    end

    always_comb begin
        if (state_next == S_READ) begin
            rd_addr_next = AW'(k_next);
        end else if (int'(pos_next) < DEPTH) begin
            rd_addr_next = AW'(pos_next);
        end else begin
            rd_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        ecount_reg <= ecount_next;
    end

    assign pos      = pos_reg;
    assign count    = count_reg;
    assign rd_index = rd_idx_reg;
    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_index  = index_reg;
    assign m_value  = value_reg;
    assign m_char   = char_reg;
    assign m_last   = last_reg;
    assign m_count  = ecount_reg;

endmodule

@@ rtl/symbol_table_lookup_unit.sv @@
`timescale 1ns / 1ps
// Push and find take their character items back to back while the output is free; the
// final item's result is registered and appears in the cycle after acceptance.
// A read by index passes its first character through the entry's registered name memory
// port and then the output register, then one character per cycle while not stalled.
// Reset (aresetn low, synchronous) empties the table and any name run in progress.

module symbol_table_lookup_unit import stl_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int NAME_LEN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // name_char, value_in, entry_index
    input  logic [1:0]  s_tuser,  // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // status, found_index, value_out, char_out, entry_count
    output logic        m_tlast
);

    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int PW    = $clog2(NAME_LEN + 1);
    localparam int DEPTH = NAME_LEN - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(NAME_LEN);

    logic [7:0]    name_char;
    logic [31:0]   value_in;
    logic [3:0]    entry_index;
    stl_ctl_t      ctl;
    logic [PW-1:0] pos;
    logic [AW-1:0] rd_addr_next;
    logic [CW-1:0] count;
    logic [3:0]    rd_index;
    chain_t        chain_w [ENTRIES + 1];
    logic [LW-1:0] len_w   [ENTRIES + 1];
    logic [2:0]    m_status;
    logic [3:0]    m_index;
    logic [31:0]   m_value;
    logic [7:0]    m_char;
    logic [4:0]    m_count;

    assign name_char   = s_tdata[7:0];
    assign value_in    = s_tdata[39:8];
    assign entry_index = s_tdata[43:40];

    assign chain_w[0] = '0;
    assign len_w[0]   = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        stl_cell #(
            .CELL_IDX (i),
            .NAME_LEN (NAME_LEN),
            .CW       (CW),
            .PW       (PW),
            .AW       (AW),
            .LW       (LW)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .name_char    (name_char),
            .pos          (pos),
            .rd_addr_next (rd_addr_next),
            .value_in     (value_in),
            .count        (count),
            .rd_index     (rd_index),
            .chain_in     (chain_w[i]),
            .len_in       (len_w[i]),
            .chain_out    (chain_w[i+1]),
            .len_out      (len_w[i+1])
        );
    end

    stl_ctrl #(
        .ENTRIES  (ENTRIES),
        .NAME_LEN (NAME_LEN),
        .CW       (CW),
        .PW       (PW),
        .AW       (AW),
        .LW       (LW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .op           (s_tuser),
        .name_last    (s_tlast),
        .value_in     (value_in),
        .entry_index  (entry_index),
        .chain_end    (chain_w[ENTRIES]),
        .len_end      (len_w[ENTRIES]),
        .ctl          (ctl),
        .pos          (pos),
        .rd_addr_next (rd_addr_next),
        .count        (count),
        .rd_index     (rd_index),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_status     (m_status),
        .m_index      (m_index),
        .m_value      (m_value),
        .m_char       (m_char),
        .m_last       (m_tlast),
        .m_count      (m_count)
    );

    assign m_tdata = {4'b0000, m_count, m_char, m_value, m_index, m_status};

endmodule
